// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SWB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition implies another one in the following cycle.
`define SWB_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define SWB_ASSERT(lbl, prop, msg)
`define SWB_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// ----- rtl/swb_pkg.sv -----
// ----------------------------------------------------------------------------
// swb_pkg
// Shared codes and types of the SPI slave window bus block.
// ----------------------------------------------------------------------------
package swb_pkg;

	// bus phase codes
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ADDR = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_RX   = 3'd3;
	localparam logic [2:0] PH_TX   = 3'd4;

	// event codes
	localparam logic [1:0] ACT_SEL_ON  = 2'd0;
	localparam logic [1:0] ACT_SEL_OFF = 2'd1;
	localparam logic [1:0] ACT_RX_BYTE = 2'd2;
	localparam logic [1:0] ACT_LOCAL   = 2'd3;

	localparam logic [7:0] READY_STATUS = 8'h02;
	localparam logic [7:0] CMD_READ     = 8'h20;
	localparam logic [7:0] CMD_WRITE    = 8'h30;
	localparam logic [7:0] CMD_MASK     = 8'hf0;

	// configuration register indexes
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	// buffer write request
	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} swb_wr_t;

endpackage

// ----- rtl/swb_if.sv -----
// ----------------------------------------------------------------------------
// swb_if
// Valid/ready channels for bus events and per-event results.
// ----------------------------------------------------------------------------
interface swb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [5:0] local_index;
	logic [7:0] local_value;

	modport source(output valid, action, rx_byte, local_index, local_value, input ready);
	modport sink(input valid, action, rx_byte, local_index, local_value, output ready);
endinterface

interface swb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       miso_enable;
	logic [2:0] bus_phase;
	logic       stored_valid;
	logic [5:0] stored_index;

	modport source(output valid, tx_byte, miso_enable, bus_phase, stored_valid,
		stored_index, input ready);
	modport sink(input valid, tx_byte, miso_enable, bus_phase, stored_valid,
		stored_index, output ready);
endinterface

// ----- rtl/spi_slave_window_bus_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// spi_slave_window_bus_fsm_unit
// Slave side of a byte-framed SPI bus with an address window and buffer.
// ----------------------------------------------------------------------------
// Usage:
//   ev  : event words (select on/off, received byte, local buffer write).
//   res : one result word per event: tx byte, MISO enable, phase after the
//         event, and the buffer entry stored by a master write.
//   APB : base_address at 0x0, window_size at 0x4; pready is always high.
// Each event is handled in the cycle it is accepted and its result lands in
// the result register at that edge; one event per cycle is sustained while
// results are taken. The buffer read port is kept ahead on the next buffer
// pointer, so a transmit byte never waits on the memory.
// A stalled result holds; ev stays ready while the result register is empty
// or being taken in the same cycle, so only a full, stalled result blocks.
// Reset clears configuration, bus state, result valid and buffer valid bits,
// so the whole buffer reads as zero right after reset with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_slave_window_bus_fsm_unit
	import swb_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	swb_in_if.sink       ev,
	swb_out_if.source    res,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [7:0] DEPTH8 = 8'(BUFFER_DEPTH);

	// configuration
	logic [15:0] base_q;
	logic [6:0]  window_q;

	// bus state
	logic [2:0]  phase_q, phase_d;
	logic [15:0] addr_q, addr_d;
	logic [6:0]  ptr_q, ptr_d;
	logic [7:0]  out_byte_q, out_byte_d;
	logic        miso_q, miso_d;

	// result register
	logic        res_valid_q;
	logic [7:0]  res_tx_q;
	logic        res_miso_q;
	logic [2:0]  res_phase_q;
	logic        res_st_valid_q;
	logic [5:0]  res_st_index_q;

	logic        accept;
	logic        st_valid;
	logic [6:0]  limit;
	logic        in_range;
	logic        hit;
	logic [15:0] addr_full;
	logic [16:0] win_end;
	logic [7:0]  rd_data;
	swb_wr_t     wr;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W+6:0] ptr_ext;
	logic [IDX_W+6:0] ptr_d_ext;
	logic [IDX_W+5:0] lidx_ext;
	logic        local_ok;

	// APB: write at the access phase, read returns the register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			window_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_BASE:   base_q   <= pwdata[15:0];
				REG_WINDOW: window_q <= pwdata[6:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BASE:   prdata = {16'd0, base_q};
			REG_WINDOW: prdata = {25'd0, window_q};
			default:    prdata = '0;
		endcase
	end

	// take a new event unless a finished result is stuck downstream
	assign ev.ready = !res_valid_q || res.ready;
	assign accept   = ev.valid && ev.ready;

	// transfers stop at the smaller of the window and the buffer
	assign limit    = ({1'b0, window_q} < DEPTH8) ? window_q : DEPTH8[6:0];
	assign in_range = (ptr_q < limit);

	// address high byte completes the address; compare in 17 bits
	assign addr_full = addr_q | {ev.rx_byte, 8'd0};
	assign win_end   = {1'b0, base_q} + {10'd0, window_q};
	assign hit       = (addr_full >= base_q) && ({1'b0, addr_full} < win_end);

	assign ptr_ext   = {{IDX_W{1'b0}}, ptr_q};
	assign ptr_d_ext = {{IDX_W{1'b0}}, ptr_d};
	assign lidx_ext  = {{IDX_W{1'b0}}, ev.local_index};
	assign local_ok  = ({2'b00, ev.local_index} < DEPTH8);

	always_comb begin
		phase_d    = phase_q;
		addr_d     = addr_q;
		ptr_d      = ptr_q;
		out_byte_d = out_byte_q;
		miso_d     = miso_q;
		st_valid   = 1'b0;
		wr.en      = 1'b0;
		wr.data    = ev.local_value;
		wr_idx     = lidx_ext[IDX_W-1:0];
		if (accept) begin
			case (ev.action)
				ACT_SEL_OFF: begin
					// drop the bus, keep pointer and tx byte
					phase_d = PH_IDLE;
					addr_d  = '0;
					miso_d  = 1'b0;
				end
				ACT_LOCAL: begin
					wr.en = local_ok;
				end
				ACT_RX_BYTE: begin
					unique case (phase_q)
						PH_IDLE: begin
							addr_d  = addr_q | {8'd0, ev.rx_byte};
							phase_d = PH_ADDR;
						end
						PH_ADDR: begin
							if (hit) begin
								addr_d     = addr_full;
								miso_d     = 1'b1;
								out_byte_d = READY_STATUS;
								phase_d    = PH_CMD;
							end else begin
								phase_d = PH_IDLE;
								addr_d  = '0;
								miso_d  = 1'b0;
							end
						end
						PH_CMD: begin
							// unknown command: stay here, pointer still cleared
							if ((ev.rx_byte & CMD_MASK) == CMD_READ) begin
								phase_d = PH_TX;
							end else if ((ev.rx_byte & CMD_MASK) == CMD_WRITE) begin
								phase_d = PH_RX;
							end
							ptr_d = '0;
						end
						PH_RX: begin
							if (in_range) begin
								wr.en      = 1'b1;
								wr.data    = ev.rx_byte;
								wr_idx     = ptr_ext[IDX_W-1:0];
								out_byte_d = ev.rx_byte;
								st_valid   = 1'b1;
								ptr_d      = ptr_q + 7'd1;
							end else begin
								phase_d = PH_IDLE;
								addr_d  = '0;
								miso_d  = 1'b0;
							end
						end
						PH_TX: begin
							if (in_range) begin
								out_byte_d = rd_data;
								ptr_d      = ptr_q + 7'd1;
							end else begin
								phase_d = PH_IDLE;
								addr_d  = '0;
								miso_d  = 1'b0;
							end
						end
						default: begin
							phase_d = PH_IDLE;
							addr_d  = '0;
							miso_d  = 1'b0;
						end
					endcase
				end
				default: ;  // select asserted: nothing to do
			endcase
		end
	end

	// prefetch the entry the pointer will point at after this edge
	assign rd_idx = ptr_d_ext[IDX_W-1:0];

	swb_buffer #(
		.DEPTH(BUFFER_DEPTH)
	) u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_idx  (wr_idx),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			addr_q     <= '0;
			ptr_q      <= '0;
			out_byte_q <= '0;
			miso_q     <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			addr_q     <= addr_d;
			ptr_q      <= ptr_d;
			out_byte_q <= out_byte_d;
			miso_q     <= miso_d;
		end
	end

	// result register: load on accept, drain when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_tx_q       <= out_byte_d;
			res_miso_q     <= miso_d;
			res_phase_q    <= phase_d;
			res_st_valid_q <= st_valid;
			res_st_index_q <= st_valid ? ptr_q[5:0] : 6'd0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.tx_byte      = res_tx_q;
	assign res.miso_enable  = res_miso_q;
	assign res.bus_phase    = res_phase_q;
	assign res.stored_valid = res_st_valid_q;
	assign res.stored_index = res_st_index_q;

	`SWB_ASSERT(a_miso_phase, miso_q == (phase_q == PH_CMD || phase_q == PH_RX || phase_q == PH_TX), "MISO drive out of step with bus phase")
	`SWB_ASSERT(a_store_phase, !(res_valid_q && res_st_valid_q) || res_phase_q == PH_RX, "master store reported outside receive phase")
	`SWB_ASSERT(a_stall_only_full, ev.ready || res_valid_q, "event channel blocked with empty result register")
	`SWB_ASSERT_NEXT(a_accept_loads, accept, res_valid_q, "accepted event left no result")

endmodule

// ----- rtl/swb_buffer.sv -----
// ----------------------------------------------------------------------------
// swb_buffer
// Window buffer: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module swb_buffer
	import swb_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swb_wr_t          wr,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [7:0]       rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_q;
	logic             rd_ok;
	logic             wr_ok;

	assign rd_ok = ({1'b0, rd_idx} < (IDX_W + 1)'(DEPTH));
	assign wr_ok = wr.en && ({1'b0, wr_idx} < (IDX_W + 1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx] <= wr.data;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (wr_ok && wr_idx == rd_idx) begin
			rd_q <= wr.data;
		end else if (rd_ok && valid_q[rd_idx]) begin
			rd_q <= mem[rd_idx];
		end else begin
			rd_q <= '0;
		end
	end

	assign rd_data = rd_q;

endmodule
